// ===== sv/lpk_pkg.sv =====
// shared types, widths and constants for the lattice point korobov transform
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package lpk_pkg;

   localparam int FIELD_W         = 32;
   localparam int FRAC_W          = 32;
   localparam int COORD_FRAC_BITS = 31;
   localparam int WEIGHT_INT_BITS = 24;
   localparam int COORD_W         = 32;
   localparam int WEIGHT_OUT_W    = 56;

   localparam int WEIGHT_W = WEIGHT_INT_BITS + FRAC_W;
   localparam int Y_W      = FRAC_W + 1;
   localparam int POLY_W   = 39;
   localparam int JAC_W    = 40;

   localparam int MUL_DIGIT_W = 4;
   localparam int MUL_A_W     = WEIGHT_W;
   localparam int MUL_B_W     = JAC_W;
   localparam int MUL_DIGITS  = MUL_B_W / MUL_DIGIT_W;
   localparam int MUL_CNT_W   = $clog2(MUL_DIGITS);
   localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
   localparam int MUL_HI_W    = MUL_P_W - FRAC_W;
   localparam int MUL_SUM_W   = MUL_A_W + MUL_DIGIT_W;

   localparam int DIV_DVD_W = 3 * FIELD_W;
   localparam int DIV_CNT_W = $clog2(DIV_DVD_W);

   localparam int COORD_SHL = (COORD_FRAC_BITS >= FRAC_W) ? COORD_FRAC_BITS - FRAC_W : 0;
   localparam int COORD_SHR = (COORD_FRAC_BITS >= FRAC_W) ? 0 : FRAC_W - COORD_FRAC_BITS;

   localparam int POLY_C0   = 35;
   localparam int POLY_C1   = 84;
   localparam int POLY_C2   = 70;
   localparam int POLY_C3   = 20;
   localparam int JAC_SCALE = 140;

   localparam logic [FIELD_W-1:0]  LATTICE_RESET = FIELD_W'(8191);
   localparam logic [Y_W-1:0]      ONE_Q         = {1'b1, {FRAC_W{1'b0}}};
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE    = WEIGHT_W'(ONE_Q);
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX    = {WEIGHT_W{1'b1}};

   typedef struct packed {
      logic [FIELD_W-1:0] point_index;
      logic [FIELD_W-1:0] generator_component;
      logic [FIELD_W-1:0] shift_fraction;
      logic               first_dimension;
      logic               last_dimension;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0]      coordinate;
      logic [WEIGHT_OUT_W-1:0] point_weight;
      logic                    index_out_of_range;
      logic                    point_complete;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROD,
      ST_DIV,
      ST_X2,
      ST_X3,
      ST_X4,
      ST_PSI,
      ST_Y2,
      ST_Y3,
      ST_XY,
      ST_WT,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

// ===== sv/lpk_serial_mul.sv =====
// radix-16 shift-add multiplier, one digit of b per cycle, full-width product
// depends on lpk_pkg
`timescale 1ns / 1ps
`default_nettype none

module lpk_serial_mul (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [lpk_pkg::MUL_A_W-1:0]     a,
   input  logic [lpk_pkg::MUL_B_W-1:0]     b,
   output lpk_pkg::unit_status_type        status,
   output logic [lpk_pkg::MUL_P_W-1:0]     product
);
   import lpk_pkg::*;

   logic [MUL_A_W-1:0]   a_ff, a_in;
   logic [MUL_A_W-1:0]   acc_ff, acc_in;
   logic [MUL_B_W-1:0]   b_ff, b_in;
   logic [MUL_CNT_W-1:0] count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MUL_SUM_W-1:0] partial;
   logic [MUL_SUM_W-1:0] sum;

   assign partial = MUL_SUM_W'(a_ff) * MUL_SUM_W'(b_ff[MUL_DIGIT_W-1:0]);
   assign sum     = MUL_SUM_W'(acc_ff) + partial;

   always_comb begin
      a_in     = a_ff;
      acc_in   = acc_ff;
      b_in     = b_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         a_in     = a;
         b_in     = b;
         acc_in   = '0;
         count_in = MUL_CNT_W'(MUL_DIGITS - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in   = sum[MUL_SUM_W-1:MUL_DIGIT_W];
         b_in     = {sum[MUL_DIGIT_W-1:0], b_ff[MUL_B_W-1:MUL_DIGIT_W]};
         count_in = count_ff - MUL_CNT_W'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      acc_ff <= acc_in;
      b_ff   <= b_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = {acc_ff, b_ff};

endmodule

`default_nettype wire

// ===== sv/lpk_serial_div.sv =====
// restoring radix-2 divider: reduces a 64-bit product mod n and then forms
// floor(r * 2^32 / n), one quotient bit per cycle; depends on lpk_pkg
`timescale 1ns / 1ps
`default_nettype none

module lpk_serial_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [lpk_pkg::DIV_DVD_W-lpk_pkg::FIELD_W-1:0] dividend,
   input  logic [lpk_pkg::FIELD_W-1:0]           divisor,
   output lpk_pkg::unit_status_type              status,
   output logic [lpk_pkg::FIELD_W-1:0]           quotient
);
   import lpk_pkg::*;

   logic [DIV_DVD_W-1:0] dvd_ff, dvd_in;
   logic [FIELD_W-1:0]   divisor_ff, divisor_in;
   logic [FIELD_W-1:0]   rem_ff, rem_in;
   logic [FIELD_W-1:0]   quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [FIELD_W:0]     trial;
   logic [FIELD_W:0]     diff;
   logic                 fits;

   assign trial = {rem_ff, dvd_ff[DIV_DVD_W-1]};
   assign fits  = trial >= {1'b0, divisor_ff};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      dvd_in     = dvd_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         // product bits first, then zeros for the fraction
         dvd_in     = {dividend, {FIELD_W{1'b0}}};
         divisor_in = divisor;
         rem_in     = '0;
         quo_in     = '0;
         count_in   = DIV_CNT_W'(DIV_DVD_W - 1);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         dvd_in   = {dvd_ff[DIV_DVD_W-2:0], 1'b0};
         rem_in   = fits ? diff[FIELD_W-1:0] : trial[FIELD_W-1:0];
         quo_in   = {quo_ff[FIELD_W-2:0], fits};
         count_in = count_ff - DIV_CNT_W'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff     <= dvd_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

`default_nettype wire

// ===== sv/lattice_point_korobov_transform.sv =====
// top level: sequencer, operand registers, result register and csr
// depends on lpk_pkg, lpk_serial_mul and lpk_serial_div
`timescale 1ns / 1ps
`default_nettype none

// Takes one dimension of one shifted rank-1 lattice point per request beat and
// returns one response beat: the Korobov r=3 transformed coordinate (Q1.31,
// clamped to 1.0), the running weight (Q24.32, saturating, restarted at one by
// first_dimension), an out-of-range flag for point_index >= lattice_size and a
// copy of last_dimension. One item is worked at a time, and it is held at the
// end until the response register is free. A 96-step restoring divider (one
// bit per cycle) reduces index*generator mod n and forms the lattice fraction,
// and nine multiplies of 10 radix-16 digits each run on one shared shift-add
// multiplier. A finished response waits in its own register, so the next
// request is taken while it is pending. The user must write lattice_size through
// the csr port only while no item is in flight; the block does not enforce this.
// The write takes effect at once and is never stalled.
module lattice_point_korobov_transform (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  lpk_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output lpk_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [lpk_pkg::FIELD_W-1:0]  csr_data
);
   import lpk_pkg::*;

   state_type            state_ff, state_in;
   logic                 issue_ff, issue_in;
   logic [FIELD_W-1:0]   lattice_size_ff, lattice_size_in;
   logic [WEIGHT_W-1:0]  weight_ff, weight_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   req_type              req_ff, req_in;
   logic [FRAC_W-1:0]    u_ff, u_in;
   logic [FRAC_W-1:0]    x2_ff, x2_in;
   logic [FRAC_W-1:0]    x3_ff, x3_in;
   logic [FRAC_W-1:0]    x4_ff, x4_in;
   logic [POLY_W-1:0]    poly_ff, poly_in;
   logic [Y_W-1:0]       psi_ff, psi_in;
   logic [Y_W-1:0]       y2_ff, y2_in;
   logic [Y_W-1:0]       y3_ff, y3_in;
   logic [JAC_W-1:0]     jac_ff, jac_in;

   logic                 mul_start;
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   unit_status_type      mul_status;
   logic [MUL_P_W-1:0]   mul_product;
   logic [MUL_HI_W-1:0]  mul_hi;
   logic [FRAC_W-1:0]    mul_frac;

   logic                 div_start;
   unit_status_type      div_status;
   logic [FIELD_W-1:0]   div_quotient;
   logic [FIELD_W-1:0]   lattice_part;

   logic [Y_W-1:0]       y_val;
   logic [POLY_W-1:0]    poly_pos;
   logic [POLY_W-1:0]    poly_neg;
   logic [WEIGHT_W-1:0]  weight_src;
   logic [2*FIELD_W-1:0] psi_wide;
   logic [COORD_W-1:0]   coord_val;

   lpk_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .status  (mul_status),
      .product (mul_product)
   );

   lpk_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_product[DIV_DVD_W-FIELD_W-1:0]),
      .divisor  (lattice_size_ff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   assign mul_hi       = mul_product[MUL_P_W-1:FRAC_W];
   assign mul_frac     = mul_product[FRAC_W +: FRAC_W];
   assign lattice_part = (lattice_size_ff == '0) ? '0 : div_quotient;
   assign y_val        = ONE_Q - Y_W'(u_ff);
   assign weight_src   = req_ff.first_dimension ? WEIGHT_ONE : weight_ff;

   // 35 + 70x^2 against 84x + 20x^3, all Q.32
   assign poly_pos = (POLY_W'(POLY_C0) << FRAC_W) + POLY_W'(x2_ff) * POLY_W'(POLY_C2);
   assign poly_neg = POLY_W'(u_ff) * POLY_W'(POLY_C1) + POLY_W'(x3_ff) * POLY_W'(POLY_C3);

   assign psi_wide  = (2*FIELD_W)'(psi_ff);
   assign coord_val = COORD_W'((psi_wide << COORD_SHL) >> COORD_SHR);

   always_comb begin
      state_in        = state_ff;
      issue_in        = 1'b0;
      lattice_size_in = csr_valid ? csr_data : lattice_size_ff;
      weight_in       = weight_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_data_in     = rsp_data_ff;
      req_in          = req_ff;
      u_in            = u_ff;
      x2_in           = x2_ff;
      x3_in           = x3_ff;
      x4_in           = x4_ff;
      poly_in         = poly_ff;
      psi_in          = psi_ff;
      y2_in           = y2_ff;
      y3_in           = y3_ff;
      jac_in          = jac_ff;
      req_ready       = 1'b0;
      mul_start       = 1'b0;
      mul_a           = '0;
      mul_b           = '0;
      div_start       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_PROD;
               issue_in = 1'b1;
            end
         end
         ST_PROD: begin
            mul_a     = MUL_A_W'(req_ff.generator_component);
            mul_b     = MUL_B_W'(req_ff.point_index);
            mul_start = issue_ff;
            if (!issue_ff && mul_status.done) begin
               state_in = ST_DIV;
               issue_in = 1'b1;
            end
         end
         ST_DIV: begin
            div_start = issue_ff;
            if (!issue_ff && div_status.done) begin
               u_in     = lattice_part + req_ff.shift_fraction;
               state_in = ST_X2;
               issue_in = 1'b1;
            end
         end
         ST_X2: begin
            mul_a     = MUL_A_W'(u_ff);
            mul_b     = MUL_B_W'(u_ff);
            mul_start = issue_ff;
            if (!issue_ff && mul_status.done) begin
               x2_in    = mul_frac;
               state_in = ST_X3;
               issue_in = 1'b1;
            end
         end
         ST_X3: begin
            mul_a     = MUL_A_W'(x2_ff);
            mul_b     = MUL_B_W'(u_ff);
            mul_start = issue_ff;
            if (!issue_ff && mul_status.done) begin
               x3_in    = mul_frac;
               state_in = ST_X4;
               issue_in = 1'b1;
            end
         end
         ST_X4: begin
            mul_a     = MUL_A_W'(x2_ff);
            mul_b     = MUL_B_W'(x2_ff);
            mul_start = issue_ff;
            if (!issue_ff && mul_status.done) begin
               x4_in    = mul_frac;
               poly_in  = (poly_pos > poly_neg) ? poly_pos - poly_neg : '0;
               state_in = ST_PSI;
               issue_in = 1'b1;
            end
         end
         ST_PSI: begin
            mul_a     = MUL_A_W'(poly_ff);
            mul_b     = MUL_B_W'(x4_ff);
            mul_start = issue_ff;
            if (!issue_ff && mul_status.done) begin
               psi_in   = (mul_hi > MUL_HI_W'(ONE_Q)) ? ONE_Q : mul_product[FRAC_W +: Y_W];
               state_in = ST_Y2;
               issue_in = 1'b1;
            end
         end
         ST_Y2: begin
            mul_a     = MUL_A_W'(y_val);
            mul_b     = MUL_B_W'(y_val);
            mul_start = issue_ff;
            if (!issue_ff && mul_status.done) begin
               y2_in    = mul_product[FRAC_W +: Y_W];
               state_in = ST_Y3;
               issue_in = 1'b1;
            end
         end
         ST_Y3: begin
            mul_a     = MUL_A_W'(y2_ff);
            mul_b     = MUL_B_W'(y_val);
            mul_start = issue_ff;
            if (!issue_ff && mul_status.done) begin
               y3_in    = mul_product[FRAC_W +: Y_W];
               state_in = ST_XY;
               issue_in = 1'b1;
            end
         end
         ST_XY: begin
            mul_a     = MUL_A_W'(y3_ff);
            mul_b     = MUL_B_W'(x3_ff);
            mul_start = issue_ff;
            if (!issue_ff && mul_status.done) begin
               jac_in   = JAC_W'(mul_frac) * JAC_W'(JAC_SCALE);
               state_in = ST_WT;
               issue_in = 1'b1;
            end
         end
         ST_WT: begin
            mul_a     = MUL_A_W'(weight_src);
            mul_b     = MUL_B_W'(jac_ff);
            mul_start = issue_ff;
            if (!issue_ff && mul_status.done) begin
               weight_in = (mul_hi > MUL_HI_W'(WEIGHT_MAX)) ? WEIGHT_MAX
                                                            : mul_product[FRAC_W +: WEIGHT_W];
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                   = 1'b1;
               rsp_data_in.coordinate         = coord_val;
               rsp_data_in.point_weight       = WEIGHT_OUT_W'(weight_ff);
               rsp_data_in.index_out_of_range = req_ff.point_index >= lattice_size_ff;
               rsp_data_in.point_complete     = req_ff.last_dimension;
               state_in                       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         issue_ff        <= 1'b0;
         lattice_size_ff <= LATTICE_RESET;
         weight_ff       <= WEIGHT_ONE;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         issue_ff        <= issue_in;
         lattice_size_ff <= lattice_size_in;
         weight_ff       <= weight_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      req_ff      <= req_in;
      u_ff        <= u_in;
      x2_ff       <= x2_in;
      x3_ff       <= x3_in;
      x4_ff       <= x4_in;
      poly_ff     <= poly_in;
      psi_ff      <= psi_in;
      y2_ff       <= y2_in;
      y3_ff       <= y3_in;
      jac_ff      <= jac_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_status.busy && div_status.busy))
      else $error("multiplier and divider busy together");

   a_idle_units_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!mul_status.busy && !div_status.busy))
      else $error("arithmetic unit still busy while idle");

   a_mul_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      mul_status.done |-> $past(mul_status.busy))
      else $error("multiplier done without a running product");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("response raised outside the emit step");

endmodule

`default_nettype wire
